/* src/dq_pkg.sv */
package dq_pkg;

  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned DataWidth   = 32;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_now;
    logic load_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic peek_hit;
    logic hold_full;
  } ctrl_sts_t;

  typedef struct packed {
    logic [StatusWidth-1:0]      status;
    logic signed [DataWidth-1:0] value;
    logic                        empty;
  } result_t;

endpackage

/* src/dq_ram.sv */
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/dq_ctrl.sv */
module dq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dq_pkg::ctrl_sts_t sts_i,
  output dq_pkg::ctrl_cmd_t cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.hold_full && sts_i.peek_hit) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.load_now  = 1'b0;
    cmd_o.load_read = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o     = !sts_i.hold_full;
        cmd_o.accept   = in_valid_i && !sts_i.hold_full;
        cmd_o.load_now = in_valid_i && !sts_i.hold_full && !sts_i.peek_hit;
      end
      S_READ: begin
        cmd_o.load_read = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* src/dq_datapath.sv */
module dq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [dq_pkg::CmdWidth-1:0]         command_i,
  input  logic signed [dq_pkg::DataWidth-1:0] push_value_i,
  input  dq_pkg::ctrl_cmd_t                   cmd_i,
  output dq_pkg::ctrl_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dq_pkg::result_t                     result_o
);
  import dq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = IW + 1;

  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty;
  logic [IW-1:0] front_inc, front_dec, tail_addr, back_addr;
  logic [SW-1:0] tail_sum, back_sum;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [DataWidth-1:0] rdata;
  logic          is_peek;
  status_e       status;

  result_t out_q, out_d, hold_q, hold_d, prod;
  logic    out_valid_q, out_valid_d, hold_valid_q, hold_valid_d;
  logic    prod_valid, out_take;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - 1'b1;
  assign tail_sum  = SW'(front_q) + SW'(count_q);
  assign back_sum  = tail_sum - 1'b1;
  assign tail_addr = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign back_addr = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    we      = 1'b0;
    waddr   = tail_addr;
    raddr   = front_q;
    is_peek = 1'b0;
    status  = ST_OK;
    case (cmd_e'(command_i))
      CMD_PUSH_FRONT: begin
        waddr = front_dec;
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = cmd_i.accept;
          front_d = front_dec;
          count_d = count_q + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = cmd_i.accept;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          front_d = front_inc;
          count_d = count_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      CMD_PEEK_FRONT: begin
        is_peek = 1'b1;
        if (empty) status = ST_EMPTY;
      end
      CMD_PEEK_BACK: begin
        is_peek = 1'b1;
        raddr   = back_addr;
        if (empty) status = ST_EMPTY;
      end
      default: ;
    endcase
  end

  assign sts_o.peek_hit  = is_peek && !empty;
  assign sts_o.hold_full = hold_valid_q;
  assign re = cmd_i.accept && is_peek && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  dq_ram #(
    .Width(DataWidth),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(push_value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // result staging: output register plus one hold slot
  always_comb begin
    prod_valid   = cmd_i.load_now || cmd_i.load_read;
    prod.status  = ST_OK;
    prod.value   = '0;
    prod.empty   = 1'b0;
    if (cmd_i.load_read) begin
      prod.value = $signed(rdata);
    end else begin
      prod.status = status;
      prod.empty  = (count_d == '0);
    end
    out_take     = out_valid_q && out_ready_i;
    out_d        = out_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;
    hold_valid_d = hold_valid_q;
    if (hold_valid_q) begin
      if (out_take) begin
        out_d        = hold_q;
        hold_valid_d = 1'b0;
      end
    end else if (prod_valid) begin
      if (!out_valid_q || out_take) begin
        out_d       = prod;
        out_valid_d = 1'b1;
      end else begin
        hold_d       = prod;
        hold_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

/* src/double_ended_queue.sv */
// double-ended queue of signed 32-bit values, DEPTH entries in a circular ram
// input channel: in_valid_i/in_ready_o with command_i and push_value_i
//   command: push front, push back, pop front, pop back, peek front, peek back
// output channel: out_valid_o/out_ready_i with status_o, peek_value_o, now_empty_o
//   one result item per command item, in command order
// order: a push, a pop, a refused command or an unused code loads its result into
//   the output register (or the hold slot) from the accepting cycle; a successful
//   peek first reads the entry store through its registered read port, then loads it
// throughput: one item per cycle while in_ready_o is high, except a successful
//   peek, which holds the input while the store is read
// stall: results sit in an output register with one hold slot behind it, so one
//   more item is taken while a result waits; when both are occupied in_ready_o
//   drops until the receiver takes an item
// reset: the queue is empty and the front index is zero; store contents are
//   not cleared since only written entries are ever read
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dq_pkg::CmdWidth-1:0]         command_i,
  input  logic signed [dq_pkg::DataWidth-1:0] push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dq_pkg::StatusWidth-1:0]      status_o,
  output logic signed [dq_pkg::DataWidth-1:0] peek_value_o,
  output logic                                now_empty_o
);
  import dq_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;
  result_t   result;

  dq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (ctrl_sts),
    .cmd_o     (ctrl_cmd)
  );

  dq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .push_value_i(push_value_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (ctrl_sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign status_o     = result.status;
  assign peek_value_o = result.value;
  assign now_empty_o  = result.empty;

endmodule

/* src/dq_checker.sv */
module dq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [dq_pkg::CmdWidth-1:0]         command_i,
  input logic signed [dq_pkg::DataWidth-1:0] push_value_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [dq_pkg::StatusWidth-1:0]      status_o,
  input logic signed [dq_pkg::DataWidth-1:0] peek_value_o,
  input logic                                now_empty_o
);
  import dq_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(command_i)
      && $stable(push_value_i))
    else $error("input item changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(peek_value_o) && $stable(now_empty_o))
    else $error("output item changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> now_empty_o)
    else $error("empty status without empty flag");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> !now_empty_o)
    else $error("full status with empty flag");

  a_peek_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && peek_value_o != 0 |-> status_o == ST_OK && !now_empty_o)
    else $error("peek value on a refused or empty result");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
